// ===== src/r2h_pkg.sv =====
// Package for the RGB to HSV pixel converter: item types, sector codes and divider steps.
`default_nettype none

package r2h_pkg;

  localparam int ChanW      = 8;
  localparam int HueW       = 9;
  localparam int SatQBits   = 8;
  localparam int HueQBits   = 6;
  localparam int SatNumW    = ChanW + SatQBits;
  localparam int HueNumW    = ChanW + HueQBits;

  localparam int NumDivStages  = 4;
  localparam int StepsPerStage = 2;
  // Front stage, numerator stage, divider stages, output register.
  localparam int NumStages     = NumDivStages + 3;

  localparam logic [HueW-1:0] HueGreenOff = 9'd120;
  localparam logic [HueW-1:0] HueBlueOff  = 9'd240;
  localparam logic [HueW-1:0] HueCircle   = 9'd360;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [ChanW-1:0] saturation;
    logic [ChanW-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [ChanW-1:0] hi;
    logic [ChanW-1:0] lo;
    sector_e          sector;
    logic             neg;
    logic [ChanW-1:0] abs_diff;
  } front_t;

  typedef struct packed {
    logic [ChanW-1:0]   hi;
    logic [ChanW-1:0]   range;
    sector_e            sector;
    logic               neg;
    logic               grey;
    logic [SatNumW-1:0] sat_acc;
    logic [HueNumW-1:0] hue_acc;
  } div_t;

  // One restoring step. The accumulator holds the partial remainder above the
  // numerator bits still to be consumed; quotient bits shift in at the bottom.
  function automatic logic [SatNumW-1:0] sat_div_step(input logic [SatNumW-1:0] acc,
                                                      input logic [ChanW-1:0] d);
    logic [SatNumW:0] t;
    logic [ChanW:0]   top;
    logic             qb;
    t   = {acc, 1'b0};
    top = t[SatNumW:SatQBits];
    qb  = (top >= {1'b0, d});
    if (qb) begin
      top = top - {1'b0, d};
    end
    return {top[ChanW-1:0], t[SatQBits-1:1], qb};
  endfunction

  function automatic logic [HueNumW-1:0] hue_div_step(input logic [HueNumW-1:0] acc,
                                                      input logic [ChanW-1:0] d);
    logic [HueNumW:0] t;
    logic [ChanW:0]   top;
    logic             qb;
    t   = {acc, 1'b0};
    top = t[HueNumW:HueQBits];
    qb  = (top >= {1'b0, d});
    if (qb) begin
      top = top - {1'b0, d};
    end
    return {top[ChanW-1:0], t[HueQBits-1:1], qb};
  endfunction

endpackage

`default_nettype wire

// ===== src/rgb_to_hsv_pixel.sv =====
// Pipelined converter from one 8-bit RGB pixel to integer hue, saturation and value.
//
// Channel | Handshake                 | Item
// --------+---------------------------+------------------------------------
// input   | in_valid_i / in_stall_o   | in_pixel_i   (red, green, blue)
// output  | out_valid_o / out_stall_i | out_hsv_o    (hue, saturation, brightness)
//
// One item per cycle is taken unless every stage is full and the output is stalled.
// Two restoring dividers give two quotient bits per stage; hue needs only the first three.
// Reset clears only the stage valid bits; the datapath registers are not reset.
// A stage holds while its successor is full and held, so bubbles are squeezed out
// and a stalled output still lets items enter until every stage is full.
`default_nettype none

module rgb_to_hsv_pixel (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire r2h_pkg::pixel_t in_pixel_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output r2h_pkg::hsv_t      out_hsv_o
);

  localparam int NS = r2h_pkg::NumStages;
  localparam int ND = r2h_pkg::NumDivStages;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] adv;

  // A stage may load when it is empty or its content moves on.
  always_comb begin
    adv[NS-1] = !vld_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = vld_q[NS-1];

  // Front stage: largest and smallest channel, sector and signed difference.
  r2h_pkg::front_t front_d, front_q;

  always_comb begin
    logic [r2h_pkg::ChanW-1:0] r, g, b, a, c;
    logic [r2h_pkg::ChanW:0]   diff;
    r = in_pixel_i.red;
    g = in_pixel_i.green;
    b = in_pixel_i.blue;
    front_d.hi = (r > g) ? r : g;
    if (b > front_d.hi) begin
      front_d.hi = b;
    end
    front_d.lo = (r < g) ? r : g;
    if (b < front_d.lo) begin
      front_d.lo = b;
    end
    // Ties go to red first, then green.
    if (front_d.hi == r) begin
      front_d.sector = r2h_pkg::SEC_RED;
      a = g;
      c = b;
    end else if (front_d.hi == g) begin
      front_d.sector = r2h_pkg::SEC_GREEN;
      a = b;
      c = r;
    end else begin
      front_d.sector = r2h_pkg::SEC_BLUE;
      a = r;
      c = g;
    end
    diff             = {1'b0, a} - {1'b0, c};
    front_d.neg      = diff[r2h_pkg::ChanW];
    front_d.abs_diff = front_d.neg ? (~diff[r2h_pkg::ChanW-1:0] + 8'd1)
                                   : diff[r2h_pkg::ChanW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      front_q <= front_d;
    end
  end

  // Numerator stage: range, 255 * range and 60 * |diff| by shifts.
  r2h_pkg::div_t div_q [ND+1];
  r2h_pkg::div_t num_d;

  always_comb begin
    logic [r2h_pkg::ChanW-1:0] rng;
    rng          = front_q.hi - front_q.lo;
    num_d.hi     = front_q.hi;
    num_d.range  = rng;
    num_d.sector = front_q.sector;
    num_d.neg    = front_q.neg;
    num_d.grey   = (rng == '0);
    num_d.sat_acc = {rng, 8'd0} - {8'd0, rng};
    num_d.hue_acc = {front_q.abs_diff, 6'd0} - {4'd0, front_q.abs_diff, 2'd0};
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      div_q[0] <= num_d;
    end
  end

  // Divider stages: saturation divides by the largest channel, hue by the range.
  // Both quotients are known to fit, so the top numerator bits seed the remainder.
  for (genvar k = 0; k < ND; k++) begin : g_div
    r2h_pkg::div_t dv_d;

    always_comb begin
      dv_d = div_q[k];
      for (int s = 0; s < r2h_pkg::StepsPerStage; s++) begin
        dv_d.sat_acc = r2h_pkg::sat_div_step(dv_d.sat_acc, dv_d.hi);
        if (k * r2h_pkg::StepsPerStage + s < r2h_pkg::HueQBits) begin
          dv_d.hue_acc = r2h_pkg::hue_div_step(dv_d.hue_acc, dv_d.range);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k+2]) begin
        div_q[k+1] <= dv_d;
      end
    end
  end

  // Output stage: sector offset, sign and wrap. A grey or black pixel gives zero hue and saturation.
  r2h_pkg::hsv_t hsv_d, hsv_q;

  always_comb begin
    r2h_pkg::div_t         dl;
    logic [r2h_pkg::HueW-1:0] q9;
    dl = div_q[ND];
    q9 = {3'd0, dl.hue_acc[r2h_pkg::HueQBits-1:0]};
    case (dl.sector)
      r2h_pkg::SEC_RED: begin
        hsv_d.hue = (dl.neg && (q9 != '0)) ? (r2h_pkg::HueCircle - q9) : q9;
      end
      r2h_pkg::SEC_GREEN: begin
        hsv_d.hue = dl.neg ? (r2h_pkg::HueGreenOff - q9) : (r2h_pkg::HueGreenOff + q9);
      end
      r2h_pkg::SEC_BLUE: begin
        hsv_d.hue = dl.neg ? (r2h_pkg::HueBlueOff - q9) : (r2h_pkg::HueBlueOff + q9);
      end
      default: begin
        hsv_d.hue = '0;
      end
    endcase
    hsv_d.saturation = dl.sat_acc[r2h_pkg::SatQBits-1:0];
    hsv_d.brightness = dl.hi;
    if (dl.grey) begin
      hsv_d.hue        = '0;
      hsv_d.saturation = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NS-1]) begin
      hsv_q <= hsv_d;
    end
  end

  assign out_hsv_o = hsv_q;

`ifndef ASSERT_OFF
  // Input is held back only when no stage has room.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> (&vld_q))
    else $error("input stalled while a pipeline stage is empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o |-> (out_hsv_o.hue < r2h_pkg::HueCircle))
    else $error("hue out of range");

  // Zero saturation means a grey pixel, which must have zero hue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o && (out_hsv_o.saturation == '0) |-> (out_hsv_o.hue == '0))
    else $error("grey pixel with nonzero hue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o && (out_hsv_o.brightness == '0)
                   |-> (out_hsv_o.saturation == '0))
    else $error("black pixel with nonzero saturation");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the RGB to HSV pixel converter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod  = 10;
  localparam int ResetCycles = 10;
  localparam int RandomPixels = 1950;
  localparam int QuietTail  = 150;
  localparam int DrainCycles = 3 * r2h_pkg::NumStages;
  localparam int MaxReports = 10;

  localparam int ChanW = r2h_pkg::ChanW;
  localparam int HueW  = r2h_pkg::HueW;

  localparam int FullScale = 255;
  localparam int SectorDeg = 60;
  localparam int CircleDeg = 360;

  typedef struct {
    r2h_pkg::pixel_t px;
    bit              wait_empty;
  } pixel_req_t;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  r2h_pkg::pixel_t in_pixel_i  = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  r2h_pkg::hsv_t   out_hsv_o;

  pixel_req_t    pixel_q[$];
  r2h_pkg::hsv_t hsv_q[$];
  int            mismatch_cnt = 0;
  int            idle_pct     = 20;
  int            gap_left     = 0;
  int            stall_left   = 0;

  rgb_to_hsv_pixel u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_pixel_i  (in_pixel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_hsv_o   (out_hsv_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic r2h_pkg::hsv_t hsv_of(r2h_pkg::pixel_t px);
    int            r, g, b, hi, lo, span, hue, sat;
    r2h_pkg::hsv_t res;
    r    = px.red;
    g    = px.green;
    b    = px.blue;
    hi   = (r > g) ? r : g;
    hi   = (hi > b) ? hi : b;
    lo   = (r < g) ? r : g;
    lo   = (lo < b) ? lo : b;
    span = hi - lo;
    sat  = (hi != 0) ? (FullScale * span) / hi : 0;
    hue  = 0;
    // Ties on the largest channel go to red, then green, then blue.
    if (span != 0) begin
      if (hi == r) begin
        hue = (SectorDeg * (g - b)) / span;
      end else if (hi == g) begin
        hue = int'(r2h_pkg::HueGreenOff) + (SectorDeg * (b - r)) / span;
      end else begin
        hue = int'(r2h_pkg::HueBlueOff) + (SectorDeg * (r - g)) / span;
      end
      if (hue < 0) begin
        hue += CircleDeg;
      end
    end
    res.hue        = HueW'(hue);
    res.saturation = ChanW'(sat);
    res.brightness = ChanW'(hi);
    return res;
  endfunction

  function automatic void report_error(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxReports) begin
      $display("%t: %s", $realtime, msg);
    end
  endfunction

  function automatic void add_pixel(int r, int g, int b, bit wait_empty = 1'b0);
    pixel_req_t req;
    req.px.red     = ChanW'(r);
    req.px.green   = ChanW'(g);
    req.px.blue    = ChanW'(b);
    req.wait_empty = wait_empty;
    pixel_q.push_back(req);
  endfunction

  function automatic int chan_near(int base, int spread);
    int v;
    v = base + $urandom_range(0, 2 * spread) - spread;
    return (v < 0) ? 0 : ((v > 255) ? 255 : v);
  endfunction

  // Mix of plain random pixels and the shapes that hit ties, greys and edges.
  function automatic void add_random_pixel(bit wait_empty);
    int kind, v, w, ch[3];
    kind = $urandom_range(0, 9);
    v    = $urandom_range(0, 255);
    w    = $urandom_range(0, v);
    case (kind)
      5: begin
        ch[0] = v; ch[1] = v; ch[2] = v;
      end
      6: begin
        ch[0] = v; ch[1] = v; ch[2] = v;
        ch[$urandom_range(0, 2)] = w;
      end
      7: begin
        ch[0] = $urandom_range(0, 3);
        ch[1] = $urandom_range(0, 3);
        ch[2] = $urandom_range(0, 3);
      end
      8: begin
        for (int i = 0; i < 3; i++) begin
          w = $urandom_range(0, 2);
          ch[i] = (w == 0) ? 0 : ((w == 1) ? 255 : $urandom_range(0, 255));
        end
      end
      9: begin
        ch[0] = chan_near(v, 3); ch[1] = chan_near(v, 3); ch[2] = chan_near(v, 3);
      end
      default: begin
        ch[0] = $urandom_range(0, 255);
        ch[1] = $urandom_range(0, 255);
        ch[2] = $urandom_range(0, 255);
      end
    endcase
    add_pixel(ch[0], ch[1], ch[2], wait_empty);
  endfunction

  // Driver: presents one item at a time and records what it should produce.
  always @(posedge clk_i) begin
    bit held;
    bit send;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      held = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        hsv_q.push_back(hsv_of(in_pixel_i));
        held = 1'b0;
      end
      if (!held) begin
        send = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (pixel_q.size() != 0) begin
          if (pixel_q[0].wait_empty && hsv_q.size() != 0) begin
            send = 1'b0;
          end else if (pixel_q.size() > QuietTail && $urandom_range(0, 99) < idle_pct) begin
            gap_left = $urandom_range(1, 15) - 1;
          end else begin
            in_pixel_i <= pixel_q[0].px;
            pixel_q.pop_front();
            send = 1'b1;
            // Change the idling pressure now and then, sometimes to none at all.
            if (pixel_q.size() % 128 == 0) begin
              case ($urandom_range(0, 3))
                0: idle_pct = 0;
                1: idle_pct = 10;
                2: idle_pct = 30;
                default: idle_pct = 60;
              endcase
            end
          end
        end
        in_valid_i <= send;
      end
    end
  end

  // Monitor: checks each accepted result and stalls the output in bursts.
  always @(posedge clk_i) begin
    r2h_pkg::hsv_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (hsv_q.size() == 0) begin
          report_error($sformatf("unexpected result hue %0d saturation %0d brightness %0d",
                                 out_hsv_o.hue, out_hsv_o.saturation, out_hsv_o.brightness));
        end else begin
          want = hsv_q.pop_front();
          if (out_hsv_o.hue !== want.hue) begin
            report_error($sformatf("hue expected %0d got %0d", want.hue, out_hsv_o.hue));
          end
          if (out_hsv_o.saturation !== want.saturation) begin
            report_error($sformatf("saturation expected %0d got %0d",
                                   want.saturation, out_hsv_o.saturation));
          end
          if (out_hsv_o.brightness !== want.brightness) begin
            report_error($sformatf("brightness expected %0d got %0d",
                                   want.brightness, out_hsv_o.brightness));
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
      end else if (pixel_q.size() > QuietTail && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(1, 15);
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    // Black, white, primaries and grey levels.
    add_pixel(0, 0, 0);
    add_pixel(255, 255, 255);
    add_pixel(1, 1, 1);
    add_pixel(128, 128, 128);
    add_pixel(255, 0, 0);
    add_pixel(0, 255, 0);
    add_pixel(0, 0, 255);
    // Ties on the largest channel.
    add_pixel(255, 255, 0);
    add_pixel(0, 255, 255);
    add_pixel(255, 0, 255);
    add_pixel(200, 200, 200 - 1);
    // Negative hue that wraps, and quotients that truncate toward zero.
    add_pixel(255, 0, 1);
    add_pixel(200, 10, 11);
    add_pixel(1, 255, 0);
    add_pixel(0, 1, 255);
    add_pixel(10, 0, 255);
    add_pixel(255, 254, 254);
    add_pixel(1, 0, 0);
    add_pixel(0, 0, 1);
    add_pixel(170, 85, 255);
    add_pixel(85, 170, 0);
    add_pixel(254, 1, 128);
    for (int i = 0; i < RandomPixels; i++) begin
      add_random_pixel(i == 0 || i == RandomPixels / 2);
    end

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pixel_q.size() != 0 || in_valid_i || hsv_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (hsv_q.size() != 0) begin
      report_error($sformatf("%0d results never arrived", hsv_q.size()));
    end
    if (mismatch_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== rgb_to_hsv_pixel.f =====
src/r2h_pkg.sv
src/rgb_to_hsv_pixel.sv
tb/tb.sv
